[rtl/core/stereo_voice_mixer_core_assert.svh]
// ----------------------------------------------------------------------------
// stereo_voice_mixer_core_assert.svh
// Assertion macros used by the stereo voice mixer checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_VOICE_MIXER_CORE_ASSERT_SVH
`define STEREO_VOICE_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SVM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stereo voice mixer: assertion failed");

// Next-cycle implication, disabled while in reset.
`define SVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stereo voice mixer: assertion failed");

`endif

[rtl/core/svm_pkg.sv]
// ----------------------------------------------------------------------------
// svm_pkg
// Types and fixed constants of the stereo voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_IN_W  = 15;
    localparam int PAN_IN_W   = 14;
    localparam int PAN_FRAC_W = 12;
    localparam int FACTOR_W   = PAN_FRAC_W + 1;   // pan factor 0..1.0
    localparam int SUM_W      = 43;

    localparam logic signed [PAN_IN_W-1:0] PAN_ONE     = PAN_IN_W'(1 << PAN_FRAC_W);
    localparam logic signed [PAN_IN_W-1:0] PAN_NEG_ONE = -PAN_ONE;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_WL,   // gain * left factor
        ST_MUL_PL,   // left sample * left weight
        ST_MUL_WR,   // gain * right factor, add left product
        ST_MUL_PR,   // right sample * right weight
        ST_ACC_R,    // add right product
        ST_EMIT      // round, saturate, load output, clear sums
    } state_t;

endpackage

[rtl/core/stereo_voice_mixer_core.sv]
// ----------------------------------------------------------------------------
// stereo_voice_mixer_core
// Stereo voice mixer: weighted accumulate of voices, rounded int16 frame out.
// ----------------------------------------------------------------------------
// Each voice transaction runs ST_MUL_WL, ST_MUL_PL, ST_MUL_WR, ST_MUL_PR and
// ST_ACC_R after acceptance, then returns to ST_IDLE with ready high, driven
// by a single shared multiplier that computes both weights and both weighted
// samples in turn, with one shared saturating adder for the two sums. The
// voice that closes a frame (last_voice, or MAX_VOICES voices) also passes
// ST_EMIT to round and load the output register, waiting while the previous
// frame waits on out_ready. No memories, no clearing pass after reset.
// ----------------------------------------------------------------------------
module stereo_voice_mixer_core
    import svm_pkg::*;
#(
    parameter int MAX_VOICES     = 4096,
    parameter int GAIN_FRAC_BITS = 12
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] left_sample,
    input  logic signed [SAMPLE_W-1:0] right_sample,
    input  logic [GAIN_IN_W-1:0]       voice_gain,
    input  logic signed [PAN_IN_W-1:0] voice_pan,
    input  logic                       last_voice,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] mixed_left,
    output logic signed [SAMPLE_W-1:0] mixed_right
);

    localparam int GAIN_W  = GAIN_FRAC_BITS + 3;                 // clamped gain, up to 4.0
    localparam int GCMP_W  = (GAIN_W > GAIN_IN_W) ? GAIN_W : GAIN_IN_W;
    localparam int WGT_W   = GAIN_W + PAN_FRAC_W;               // gain * factor, unsigned
    localparam int OPA_W   = (GAIN_W + 1 > SAMPLE_W) ? GAIN_W + 1 : SAMPLE_W;
    localparam int OPB_W   = WGT_W + 1;
    localparam int PROD_W  = OPA_W + OPB_W;
    localparam int ADD_W   = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
    localparam int FRAC_W  = GAIN_FRAC_BITS + PAN_FRAC_W;
    localparam int RND_W   = SUM_W + 1;
    localparam int CNT_W   = $clog2(MAX_VOICES + 1);

    localparam logic [GCMP_W-1:0] GAIN_MAX = GCMP_W'(4 << GAIN_FRAC_BITS);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_VOICES);
    localparam logic signed [ADD_W-1:0] SUM_HI = ADD_W'({1'b0, {(SUM_W-1){1'b1}}});
    localparam logic signed [ADD_W-1:0] SUM_LO = -SUM_HI - ADD_W'(1);
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (FRAC_W - 1);

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [ADD_W-1:0] s;
        s = ADD_W'(a) + ADD_W'(b);
        if (s > SUM_HI)
            return SUM_W'(SUM_HI);
        else if (s < SUM_LO)
            return SUM_W'(SUM_LO);
        else
            return SUM_W'(s);
    endfunction

    // Half away from zero: (s + half - [s < 0]) >>> frac, then clamp to int16.
    function automatic logic signed [SAMPLE_W-1:0] round_out(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [RND_W-1:0] r;
        r = RND_W'(s) + RND_HALF - RND_W'(s[SUM_W-1]);
        r = r >>> FRAC_W;
        if (r > RND_W'(SAMPLE_MAX))
            return SAMPLE_MAX;
        else if (r < RND_W'(SAMPLE_MIN))
            return SAMPLE_MIN;
        else
            return SAMPLE_W'(r);
    endfunction

    state_t state_reg, state_next;

    logic signed [SAMPLE_W-1:0] ls_reg, rs_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic [FACTOR_W-1:0]        lf_reg, rf_reg;
    logic                       emit_reg, emit_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    left_sum_reg, left_sum_next;
    logic signed [SUM_W-1:0]    right_sum_reg, right_sum_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] mixed_left_reg, mixed_right_reg;

    logic                       accept;
    logic                       out_load;
    logic                       acc_left, acc_right;
    logic signed [OPA_W-1:0]    mul_a;
    logic signed [OPB_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [SUM_W-1:0]    acc_in, acc_res;

    logic [GCMP_W-1:0]          gain_ext;
    logic [GAIN_W-1:0]          gain_clamped;
    logic signed [PAN_IN_W-1:0] pan_clamped;
    logic signed [PAN_IN_W-1:0] lf_wide, rf_wide;
    logic [CNT_W-1:0]           cnt_inc;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_MUL_WL;
            ST_MUL_WL: state_next = ST_MUL_PL;
            ST_MUL_PL: state_next = ST_MUL_WR;
            ST_MUL_WR: state_next = ST_MUL_PR;
            ST_MUL_PR: state_next = ST_ACC_R;
            ST_ACC_R:  state_next = emit_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        in_ready  = 1'b0;
        out_load  = 1'b0;
        acc_left  = 1'b0;
        acc_right = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_MUL_WL:
            begin
                mul_a = OPA_W'(gain_reg);
                mul_b = OPB_W'(lf_reg);
            end
            ST_MUL_PL:
            begin
                mul_a = OPA_W'(ls_reg);
                mul_b = OPB_W'(prod_reg[WGT_W-1:0]);
            end
            ST_MUL_WR:
            begin
                mul_a    = OPA_W'(gain_reg);
                mul_b    = OPB_W'(rf_reg);
                acc_left = 1'b1;
            end
            ST_MUL_PR:
            begin
                mul_a = OPA_W'(rs_reg);
                mul_b = OPB_W'(prod_reg[WGT_W-1:0]);
            end
            ST_ACC_R:
            begin
                acc_right = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // ---------------- input conditioning ----------------
    always_comb
    begin
        gain_ext     = GCMP_W'(voice_gain);
        gain_clamped = (gain_ext > GAIN_MAX) ? GAIN_W'(GAIN_MAX) : GAIN_W'(gain_ext);

        if (voice_pan > PAN_ONE)
            pan_clamped = PAN_ONE;
        else if (voice_pan < PAN_NEG_ONE)
            pan_clamped = PAN_NEG_ONE;
        else
            pan_clamped = voice_pan;

        lf_wide = (pan_clamped > 0) ? PAN_ONE - pan_clamped : PAN_ONE;
        rf_wide = (pan_clamped < 0) ? PAN_ONE + pan_clamped : PAN_ONE;

        cnt_inc   = cnt_reg + CNT_W'(1);
        emit_next = emit_reg;
        cnt_next  = cnt_reg;
        if (accept)
        begin
            emit_next = last_voice || (cnt_inc == CNT_LAST);
            cnt_next  = emit_next ? '0 : cnt_inc;
        end
    end

    // ---------------- shared multiplier and adder ----------------
    assign mul_p   = mul_a * mul_b;
    assign acc_in  = acc_left ? left_sum_reg : right_sum_reg;
    assign acc_res = sat_add(acc_in, prod_reg);

    always_comb
    begin
        left_sum_next  = left_sum_reg;
        right_sum_next = right_sum_reg;
        if (acc_left)
            left_sum_next = acc_res;
        if (acc_right)
            right_sum_next = acc_res;
        if (out_load)
        begin
            left_sum_next  = '0;
            right_sum_next = '0;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (out_load)
            out_valid_next = 1'b1;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            emit_reg      <= 1'b0;
            cnt_reg       <= '0;
            left_sum_reg  <= '0;
            right_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_reg      <= emit_next;
            cnt_reg       <= cnt_next;
            left_sum_reg  <= left_sum_next;
            right_sum_reg <= right_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ls_reg   <= left_sample;
            rs_reg   <= right_sample;
            gain_reg <= gain_clamped;
            lf_reg   <= FACTOR_W'(lf_wide);
            rf_reg   <= FACTOR_W'(rf_wide);
        end
        prod_reg <= mul_p;
        if (out_load)
        begin
            mixed_left_reg  <= round_out(left_sum_reg);
            mixed_right_reg <= round_out(right_sum_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign mixed_left  = mixed_left_reg;
    assign mixed_right = mixed_right_reg;

endmodule

[rtl/core/svm_checker.sv]
// ----------------------------------------------------------------------------
// svm_checker
// Port-level checks of the stereo voice mixer, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_voice_mixer_core_assert.svh"

module svm_checker
    import svm_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic signed [SAMPLE_W-1:0] left_sample,
    input logic signed [SAMPLE_W-1:0] right_sample,
    input logic [GAIN_IN_W-1:0]       voice_gain,
    input logic signed [PAN_IN_W-1:0] voice_pan,
    input logic                       last_voice,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] mixed_left,
    input logic signed [SAMPLE_W-1:0] mixed_right
);

    logic in_xfer;

    // input payload is only sampled on a transaction
    assign in_xfer = in_valid && in_ready && (^{left_sample, right_sample, voice_gain,
                                                voice_pan, last_voice} !== 1'bx);

    // a stalled frame holds
    `SVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(mixed_left) && $stable(mixed_right))

    // one voice at a time: busy right after taking a voice
    `SVM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a frame never appears the cycle after a voice is taken
    `SVM_ASSERT_NEXT(a_no_early_frame, clk, rst_n, in_xfer, !$rose(out_valid))

    // frames are loaded only while the input side is closed
    `SVM_ASSERT_SAME(a_frame_while_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind stereo_voice_mixer_core svm_checker u_svm_checker (.*);

[tb/sv/stereo_voice_mixer_core_test.sv]
// ----------------------------------------------------------------------------
// stereo_voice_mixer_core_test
// Self-checking bench for the stereo voice mixer core. Voice transactions are
// fed from a queue by a clocked driver. Every accepted voice runs through a
// fixed-point mix model that predicts the emitted frames. A clocked monitor
// compares each output frame, in order, with the predicted one. Both sides
// idle in random bursts.
// ----------------------------------------------------------------------------
module stereo_voice_mixer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import svm_pkg::*;

    localparam int VOICE_LIMIT = 4096;
    localparam int GAIN_FRAC   = 12;
    localparam int ROUND_SHIFT = GAIN_FRAC + PAN_FRAC_W;
    localparam int CALM_TAIL   = 120;   // voices at the end sent without idling

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [GAIN_IN_W-1:0]       gain;
        logic signed [PAN_IN_W-1:0] pan;
        logic                       last;
    } voice_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } mix_frame_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       in_valid     = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] left_sample  = '0;
    logic signed [SAMPLE_W-1:0] right_sample = '0;
    logic [GAIN_IN_W-1:0]       voice_gain   = '0;
    logic signed [PAN_IN_W-1:0] voice_pan    = '0;
    logic                       last_voice   = 1'b0;
    logic                       out_valid;
    logic                       out_ready    = 1'b0;
    logic signed [SAMPLE_W-1:0] mixed_left;
    logic signed [SAMPLE_W-1:0] mixed_right;

    voice_t      voice_queue[$];
    mix_frame_t  mixed_frames_due[$];
    voice_t      cur_voice;

    // mix model state
    longint      left_acc        = 0;
    longint      right_acc       = 0;
    int          voices_in_frame = 0;

    int unsigned voices_total  = 0;
    int unsigned voices_taken  = 0;
    int unsigned frames_seen   = 0;
    int unsigned limit_frames  = 0;
    int unsigned fault_count   = 0;
    int          send_gap      = 0;
    int          stall_left    = 0;

    stereo_voice_mixer_core #(
        .MAX_VOICES     (VOICE_LIMIT),
        .GAIN_FRAC_BITS (GAIN_FRAC)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .voice_gain   (voice_gain),
        .voice_pan    (voice_pan),
        .last_voice   (last_voice),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .mixed_left   (mixed_left),
        .mixed_right  (mixed_right)
    );

    always #5 clk = ~clk;

    function automatic longint sat_accumulate(longint acc, longint term);
        longint hi;
        longint lo;
        longint s;
        hi = (longint'(1) <<< (SUM_W - 1)) - 1;
        lo = -hi - 1;
        s  = acc + term;
        if (s > hi)
            return hi;
        if (s < lo)
            return lo;
        return s;
    endfunction

    // round half away from zero, then clamp to int16
    function automatic logic signed [SAMPLE_W-1:0] round_to_pcm(longint acc);
        longint mag;
        longint r;
        mag = (acc < 0) ? -acc : acc;
        r   = (mag + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
        if (acc < 0)
            return (r > 32768) ? SAMPLE_MIN : SAMPLE_W'(-r);
        return (r > 32767) ? SAMPLE_MAX : SAMPLE_W'(r);
    endfunction

    function automatic void mix_voice(input voice_t v, output bit emit,
                                      output mix_frame_t frame);
        longint unity;
        longint gain;
        longint pan;
        longint lf;
        longint rf;
        unity = longint'(1) <<< PAN_FRAC_W;
        gain  = longint'(v.gain);
        pan   = longint'(v.pan);
        if (gain > 4 * (longint'(1) <<< GAIN_FRAC))
            gain = 4 * (longint'(1) <<< GAIN_FRAC);
        if (pan > unity)
            pan = unity;
        if (pan < -unity)
            pan = -unity;
        lf = (pan > 0) ? unity - pan : unity;
        rf = (pan < 0) ? unity + pan : unity;
        left_acc  = sat_accumulate(left_acc, longint'(v.left) * (gain * lf));
        right_acc = sat_accumulate(right_acc, longint'(v.right) * (gain * rf));
        voices_in_frame++;
        emit = v.last || voices_in_frame >= VOICE_LIMIT;
        frame.left  = round_to_pcm(left_acc);
        frame.right = round_to_pcm(right_acc);
        if (emit)
        begin
            if (!v.last)
                limit_frames++;
            left_acc        = 0;
            right_acc       = 0;
            voices_in_frame = 0;
        end
    endfunction

    // idle-free stretches every fourth block of 64 voices and in the tail
    function automatic bit idling_allowed();
        return voice_queue.size() >= CALM_TAIL && ((voices_taken >> 6) % 4) != 3;
    endfunction

    function automatic void add_voice(int l, int r, int g, int p, bit last);
        voice_t v;
        v.left  = SAMPLE_W'(l);
        v.right = SAMPLE_W'(r);
        v.gain  = GAIN_IN_W'(g);
        v.pan   = PAN_IN_W'(p);
        v.last  = last;
        voice_queue.insert(voice_queue.size(), v);
        voices_total++;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic void add_random_voice(bit last, bit quiet_gain);
        voice_t v;
        v.left  = random_sample();
        v.right = random_sample();
        case ($urandom_range(0, 9))
            0:       v.gain = '0;
            1:       v.gain = GAIN_IN_W'(16384);
            2:       v.gain = GAIN_IN_W'($urandom);
            3:       v.gain = GAIN_IN_W'($urandom_range(16385, 32767));
            default: v.gain = GAIN_IN_W'($urandom_range(0, 16384));
        endcase
        if (quiet_gain)
            v.gain = GAIN_IN_W'($urandom_range(0, 64));
        case ($urandom_range(0, 9))
            0:       v.pan = PAN_NEG_ONE;
            1:       v.pan = PAN_ONE;
            2:       v.pan = '0;
            3:       v.pan = PAN_IN_W'($urandom);
            default: v.pan = PAN_IN_W'(int'($urandom_range(0, 8192)) - 4096);
        endcase
        v.last = last;
        voice_queue.insert(voice_queue.size(), v);
        voices_total++;
    endfunction

    // driver: presents queued voices, runs the mix model on each transaction
    always @(posedge clk)
    begin : driver
        bit         emit;
        mix_frame_t frame;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                mix_voice(cur_voice, emit, frame);
                if (emit)
                    mixed_frames_due.insert(mixed_frames_due.size(), frame);
                voices_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (voice_queue.size() > 0)
                begin
                    cur_voice = voice_queue.pop_front();
                    left_sample  <= cur_voice.left;
                    right_sample <= cur_voice.right;
                    voice_gain   <= cur_voice.gain;
                    voice_pan    <= cur_voice.pan;
                    last_voice   <= cur_voice.last;
                    in_valid     <= 1'b1;
                    if (idling_allowed() && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks output frames in order, stalls out_ready in bursts
    always @(posedge clk)
    begin : monitor
        mix_frame_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                frames_seen++;
                if (mixed_frames_due.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected frame, expected none, actual L=%0d R=%0d",
                             $time, mixed_left, mixed_right);
                end
                else
                begin
                    want = mixed_frames_due.pop_front();
                    if (mixed_left !== want.left)
                    begin
                        fault_count++;
                        $display("%0t: mixed_left mismatch, expected %0d, actual %0d",
                                 $time, want.left, mixed_left);
                    end
                    if (mixed_right !== want.right)
                    begin
                        fault_count++;
                        $display("%0t: mixed_right mismatch, expected %0d, actual %0d",
                                 $time, want.right, mixed_right);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int frame_len;
        bit quiet;

        // directed: extremes, clamps, rounding ties, output saturation
        add_voice(32767, -32768, 4096, 0, 1'b1);
        add_voice(32767, -32768, 16384, 0, 1'b1);
        add_voice(-1234, 777, 0, 0, 1'b1);
        add_voice(32767, 32767, 32767, -8192, 1'b1);
        add_voice(-32768, 32767, 20000, 8191, 1'b1);
        add_voice(1000, 1000, 4096, int'(PAN_ONE), 1'b1);
        add_voice(1000, 1000, 4096, int'(PAN_NEG_ONE), 1'b1);
        add_voice(1000, -1000, 4096, 2048, 1'b1);
        add_voice(1, -1, 2048, 0, 1'b1);
        add_voice(3, -3, 2048, 0, 1'b1);
        add_voice(1, -1, 2047, 0, 1'b1);
        repeat (2)
            add_voice(-32768, 32767, 16384, 0, 1'b0);
        add_voice(-32768, 32767, 16384, 0, 1'b1);
        repeat (3)
            add_voice(32767, -32768, 32767, 0, 1'b0);
        add_voice(-32768, 32767, 16384, 0, 1'b1);
        add_voice(12000, -9000, 6000, -1000, 1'b0);
        add_voice(-7000, 15000, 3000, 3000, 1'b1);

        // random frames of mixed length, some of them at low gain
        while (voices_total < 650)
        begin
            quiet     = ($urandom_range(0, 7) == 0);
            frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                    : $urandom_range(1, 4);
            repeat (frame_len - 1)
                add_random_voice(1'b0, quiet);
            add_random_voice(1'b1, quiet);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (voices_taken < voices_total)
            @(posedge clk);
        while (mixed_frames_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mixed_frames_due.size() > 0)
            fault_count++;
        $display("Mixed %0d voice transactions into %0d frames checked;", voices_taken,
                 frames_seen);
        $display("%0d frame(s) closed by the voice limit, rest by last_voice.", limit_frames);
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #10_000_000;
        $display("Timeout with %0d of %0d voices taken", voices_taken, voices_total);
        $display("Regression FAIL");
        $finish;
    end

endmodule
